// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the bus slot arbiter
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsa assertion failed");

// next-cycle implication
`define BSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsa assertion failed");

`endif

// ===== sv/bsa_pkg.sv =====
// ---------------------------------------------------------------------------
// bsa_pkg
// types and constants of the two-way bus slot arbiter
// ---------------------------------------------------------------------------
package bsa_pkg;

    localparam int BSA_WAIT_COUNT_WIDTH = 8;
    localparam int CAP_WIDTH            = 3;
    localparam int BURST_WIDTH          = 3;
    localparam int MAX_BURST            = 7;
    localparam int APB_ADDR_WIDTH       = 3;
    localparam int APB_DATA_WIDTH       = 32;

    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 3'd3;

    typedef enum logic
    {
        REQ_SLOT    = 1'b0,
        REQ_RELEASE = 1'b1
    } req_kind_t;

    typedef enum logic
    {
        OUT_GRANT  = 1'b0,
        OUT_REFUSE = 1'b1
    } outcome_t;

    typedef enum logic
    {
        REG_SLOT_LIMIT = 1'b0
    } reg_index_t;

    typedef struct packed
    {
        logic                   outcome;
        logic                   direction;
        logic                   priority_req;
        logic [BURST_WIDTH-1:0] count;
    } burst_t;

endpackage

// ===== sv/bsa_if.sv =====
// ---------------------------------------------------------------------------
// bsa_if
// request and result channels of the bus slot arbiter
// ---------------------------------------------------------------------------
interface bsa_req_if;
    logic valid;
    logic ready;
    logic req_type;
    logic direction;
    logic priority_req;

    modport source (output valid, output req_type, output direction,
                    output priority_req, input ready);
    modport sink   (input valid, input req_type, input direction,
                    input priority_req, output ready);
endinterface

interface bsa_res_if;
    logic valid;
    logic ready;
    logic outcome;
    logic grant_direction;
    logic grant_priority;
    logic last;

    modport source (output valid, output outcome, output grant_direction,
                    output grant_priority, output last, input ready);
    modport sink   (input valid, input outcome, input grant_direction,
                    input grant_priority, input last, output ready);
endinterface

// ===== sv/bsa_slot_ctrl.sv =====
// ---------------------------------------------------------------------------
// bsa_slot_ctrl
// request register, bus state and grant decision for one request per cycle while burst_ready holds
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bsa_slot_ctrl #(
    parameter int WAIT_COUNT_WIDTH = bsa_pkg::BSA_WAIT_COUNT_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [bsa_pkg::CAP_WIDTH-1:0]  slot_limit,
    bsa_req_if.sink                        req,
    input  logic                           burst_ready,
    output logic                           burst_load,
    output bsa_pkg::burst_t                burst
);
    import bsa_pkg::*;

    localparam int W  = WAIT_COUNT_WIDTH;
    localparam int CW = (W > 3) ? W : 3;

    logic                 in_valid_reg;
    logic                 in_type_reg;
    logic                 in_dir_reg;
    logic                 in_prio_reg;
    logic                 advance;

    logic [CAP_WIDTH-1:0] running_reg, running_next;
    logic                 bus_dir_reg, bus_dir_next;
    logic [W-1:0]         nw0_reg, nw0_next;
    logic [W-1:0]         nw1_reg, nw1_next;
    logic [W-1:0]         pw0_reg, pw0_next;
    logic [W-1:0]         pw1_reg, pw1_next;

    logic                 sel_prio;
    logic                 sel_dir;
    logic [W-1:0]         sel_cnt;
    logic [W-1:0]         sel_cnt_new;
    logic                 cnt_write;
    logic [CW-1:0]        cnt_ext;
    logic [CAP_WIDTH-1:0] base_count;
    logic [CAP_WIDTH-1:0] room;
    logic [2:0]           cnt_sat;
    logic [2:0]           n_wake;
    logic                 lim_all;
    logic                 do_wake;
    logic                 pw_cur, pw_opp, nw_cur;
    logic                 cur;

    assign advance   = in_valid_reg && burst_ready;
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_type_reg <= req.req_type;
            in_dir_reg  <= req.direction;
            in_prio_reg <= req.priority_req;
        end
    end

    assign cur    = bus_dir_reg;
    assign pw_cur = (cur ? pw1_reg : pw0_reg) != '0;
    assign pw_opp = (cur ? pw0_reg : pw1_reg) != '0;
    assign nw_cur = (cur ? nw1_reg : nw0_reg) != '0;

    always_comb
    begin
        sel_prio = in_prio_reg;
        sel_dir  = in_dir_reg;
        lim_all  = 1'b0;
        do_wake  = 1'b0;
        base_count = running_reg;
        if (in_type_reg == REQ_RELEASE)
        begin
            base_count = running_reg - CAP_WIDTH'(1);
            if (pw_cur)
            begin
                sel_prio = 1'b1;
                sel_dir  = cur;
                do_wake  = 1'b1;
            end
            else if (pw_opp)
            begin
                sel_prio = 1'b1;
                sel_dir  = !cur;
                lim_all  = 1'b1;
                do_wake  = (base_count == '0);
            end
            else if (nw_cur)
            begin
                sel_prio = 1'b0;
                sel_dir  = cur;
                do_wake  = 1'b1;
            end
            else
            begin
                sel_prio = 1'b0;
                sel_dir  = !cur;
                lim_all  = 1'b1;
                do_wake  = (base_count == '0);
            end
        end
    end

    always_comb
    begin
        case ({sel_prio, sel_dir})
            2'b00:   sel_cnt = nw0_reg;
            2'b01:   sel_cnt = nw1_reg;
            2'b10:   sel_cnt = pw0_reg;
            default: sel_cnt = pw1_reg;
        endcase
    end

    assign room    = (base_count < slot_limit) ? (slot_limit - base_count) : '0;
    assign cnt_ext = CW'(sel_cnt);
    assign cnt_sat = (cnt_ext > CW'(MAX_BURST)) ? 3'(MAX_BURST) : cnt_ext[2:0];

    always_comb
    begin
        n_wake = (cnt_sat < room) ? cnt_sat : room;
        if (!lim_all && n_wake > 3'd1)
        begin
            n_wake = 3'd1;
        end
        if (!do_wake)
        begin
            n_wake = '0;
        end
    end

    always_comb
    begin
        running_next  = running_reg;
        bus_dir_next  = bus_dir_reg;
        sel_cnt_new   = sel_cnt;
        cnt_write     = 1'b0;
        burst.outcome      = OUT_GRANT;
        burst.direction    = sel_dir;
        burst.priority_req = sel_prio;
        burst.count        = '0;
        if (advance)
        begin
            if (in_type_reg == REQ_SLOT)
            begin
                if ((running_reg < slot_limit) &&
                    (running_reg == '0 || bus_dir_reg == in_dir_reg))
                begin
                    running_next = running_reg + CAP_WIDTH'(1);
                    bus_dir_next = in_dir_reg;
                    burst.count  = 3'd1;
                end
                else if (sel_cnt == '1)
                begin
                    burst.outcome = OUT_REFUSE;
                    burst.count   = 3'd1;
                end
                else
                begin
                    sel_cnt_new = sel_cnt + W'(1);
                    cnt_write   = 1'b1;
                end
            end
            else if (running_reg != '0)
            begin
                running_next = base_count + n_wake;
                if (n_wake != '0)
                begin
                    bus_dir_next = sel_dir;
                    sel_cnt_new  = sel_cnt - W'(n_wake);
                    cnt_write    = 1'b1;
                    burst.count  = n_wake;
                end
            end
        end
    end

    assign burst_load = burst.count != '0;

    always_comb
    begin
        nw0_next = nw0_reg;
        nw1_next = nw1_reg;
        pw0_next = pw0_reg;
        pw1_next = pw1_reg;
        if (cnt_write)
        begin
            case ({sel_prio, sel_dir})
                2'b00:   nw0_next = sel_cnt_new;
                2'b01:   nw1_next = sel_cnt_new;
                2'b10:   pw0_next = sel_cnt_new;
                default: pw1_next = sel_cnt_new;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= '0;
            bus_dir_reg <= 1'b0;
            nw0_reg     <= '0;
            nw1_reg     <= '0;
            pw0_reg     <= '0;
            pw1_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            bus_dir_reg <= bus_dir_next;
            nw0_reg     <= nw0_next;
            nw1_reg     <= nw1_next;
            pw0_reg     <= pw0_next;
            pw1_reg     <= pw1_next;
        end
    end

    // release on an empty bus leaves no trace
    `BSA_ASSERT_IMP(a_idle_release, clk, rst_n,
        advance && in_type_reg == REQ_RELEASE && running_reg == '0,
        !burst_load && running_next == '0)
    // a refusal never changes the running count
    `BSA_ASSERT_IMP(a_refuse_hold, clk, rst_n,
        burst_load && burst.outcome == OUT_REFUSE, running_next == running_reg)
    // any grant leaves the bus in its direction
    `BSA_ASSERT_NXT(a_grant_dir, clk, rst_n, burst_load && burst.outcome == OUT_GRANT,
        bus_dir_reg == $past(burst.direction) && running_reg != '0)

endmodule

// ===== sv/bsa_burst_out.sv =====
// ---------------------------------------------------------------------------
// bsa_burst_out
// result register that plays out a group of equal results one per cycle while res is ready
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bsa_burst_out (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            burst_load,
    input  bsa_pkg::burst_t burst,
    output logic            burst_ready,
    bsa_res_if.source       res
);
    import bsa_pkg::*;

    logic                   valid_reg;
    logic                   outcome_reg;
    logic                   dir_reg;
    logic                   prio_reg;
    logic [BURST_WIDTH-1:0] count_reg;
    logic                   is_last;
    logic                   fire;

    assign is_last     = count_reg == BURST_WIDTH'(1);
    assign fire        = valid_reg && res.ready;
    assign burst_ready = !valid_reg || (res.ready && is_last);

    assign res.valid           = valid_reg;
    assign res.outcome         = outcome_reg;
    assign res.grant_direction = dir_reg;
    assign res.grant_priority  = prio_reg;
    assign res.last            = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else if (burst_load)
        begin
            valid_reg <= 1'b1;
            count_reg <= burst.count;
        end
        else if (fire)
        begin
            valid_reg <= !is_last;
            count_reg <= count_reg - BURST_WIDTH'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst_load)
        begin
            outcome_reg <= burst.outcome;
            dir_reg     <= burst.direction;
            prio_reg    <= burst.priority_req;
        end
    end

    `BSA_ASSERT_IMP(a_count_live, clk, rst_n, valid_reg, count_reg != '0)
    `BSA_ASSERT_NXT(a_burst_cont, clk, rst_n, fire && !is_last && !burst_load, valid_reg && $stable(dir_reg))
    `BSA_ASSERT_IMP(a_load_free, clk, rst_n, burst_load, burst_ready)

endmodule

// ===== sv/two_way_bus_slot_arbiter_core.sv =====
// ---------------------------------------------------------------------------
// two_way_bus_slot_arbiter_core
// grants slots on a half-duplex shared bus with priority waiters
// ---------------------------------------------------------------------------
// channel   dir   fields                                          handshake
// req       in    req_type direction priority_req                 valid/ready
// res       out   outcome grant_direction grant_priority last     valid/ready
// apb       in    slot_limit at byte addresses 0 to 3             psel/penable
//
// a request is taken into an input register, decided from that register and its
// results (zero to seven) leave one per cycle from the result register while res is ready
// a new request can be taken every cycle while each yields at most one result and res is ready
// a release that wakes n waiters stalls the request side until its last result is taken
// res stalls hold the result register and then the input register
// reset clears the bus state and sets the capacity to three
// ---------------------------------------------------------------------------
module two_way_bus_slot_arbiter_core #(
    parameter int WAIT_COUNT_WIDTH = bsa_pkg::BSA_WAIT_COUNT_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bsa_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [bsa_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [bsa_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                pready,
    bsa_req_if.sink                             req,
    bsa_res_if.source                           res
);
    import bsa_pkg::*;

    logic [CAP_WIDTH-1:0] cap_reg;
    logic                 cap_sel;
    logic                 burst_load;
    logic                 burst_ready;
    burst_t               burst;

    assign pready  = 1'b1;
    assign cap_sel = paddr[APB_ADDR_WIDTH-1] == REG_SLOT_LIMIT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && cap_sel)
        begin
            cap_reg <= pwdata[CAP_WIDTH-1:0];
        end
    end

    assign prdata = cap_sel ? APB_DATA_WIDTH'(cap_reg) : '0;

    bsa_slot_ctrl #(
        .WAIT_COUNT_WIDTH (WAIT_COUNT_WIDTH)
    ) u_slot_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .slot_limit   (cap_reg),
        .req          (req),
        .burst_ready  (burst_ready),
        .burst_load   (burst_load),
        .burst        (burst)
    );

    bsa_burst_out u_burst_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst_load  (burst_load),
        .burst       (burst),
        .burst_ready (burst_ready),
        .res         (res)
    );

endmodule
